>>> sv/timer_sleep_wakeup_queue_defines.svh
// Assertion macros shared by the sleep queue RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef TIMER_SLEEP_WAKEUP_QUEUE_DEFINES_SVH
`define TIMER_SLEEP_WAKEUP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TSQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sleep queue check failed");

// Next-cycle implication, disabled during reset
`define TSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sleep queue check failed");

`endif

>>> sv/tsq_pkg.sv
// Shared types, constants and the microcode program of the sleep queue.
// No dependencies.
package tsq_pkg;

  localparam int MAX_SLEEPERS = 16;
  localparam int ADDR_W       = $clog2(MAX_SLEEPERS);
  localparam int CNT_W        = $clog2(MAX_SLEEPERS + 1);
  localparam int ID_W         = 8;
  localparam int TICK_W       = 63;
  localparam int DUR_W        = 32;
  localparam int KIND_W       = 3;
  localparam int ENTRY_W      = ID_W + TICK_W;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUEUED  = 3'd0,
    KIND_IGNORED = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_WOKEN   = 3'd3,
    KIND_NONE    = 3'd4
  } kind_t;

  localparam logic OP_SLEEP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Datapath action of one microcode step
  typedef enum logic [2:0] {
    ACT_FETCH  = 3'd0,
    ACT_SLEEP  = 3'd1,
    ACT_TSTART = 3'd2,
    ACT_SCAN   = 3'd3,
    ACT_FINISH = 3'd4
  } act_t;

  // Jump condition of one microcode step
  typedef enum logic [1:0] {
    COND_NEVER  = 2'd0,
    COND_ALWAYS = 2'd1,
    COND_TICK   = 2'd2,
    COND_MORE   = 2'd3
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_FETCH  = 3'd0;
  localparam step_t STEP_SLEEP  = 3'd1;
  localparam step_t STEP_TSTART = 3'd2;
  localparam step_t STEP_SCAN   = 3'd3;
  localparam step_t STEP_FINISH = 3'd4;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Status returned from the datapath to the sequencer
  typedef struct packed {
    logic hold;
    logic op_tick;
    logic more;
    logic emit;
  } dp_status_t;

  // Control store: taken jump goes to target, otherwise to the next step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      STEP_FETCH:  w = '{act: ACT_FETCH,  cond: COND_TICK,   target: STEP_TSTART};
      STEP_SLEEP:  w = '{act: ACT_SLEEP,  cond: COND_ALWAYS, target: STEP_FETCH};
      STEP_TSTART: w = '{act: ACT_TSTART, cond: COND_NEVER,  target: STEP_FETCH};
      STEP_SCAN:   w = '{act: ACT_SCAN,   cond: COND_MORE,   target: STEP_SCAN};
      STEP_FINISH: w = '{act: ACT_FINISH, cond: COND_ALWAYS, target: STEP_FETCH};
      default:     w = '{act: ACT_FETCH,  cond: COND_ALWAYS, target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

>>> sv/tsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tsq_seq.sv
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on tsq_pkg.
module tsq_seq (
  input  logic                clk,
  input  logic                rst,
  input  tsq_pkg::dp_status_t status,
  output tsq_pkg::ucode_t     ctrl
);
  import tsq_pkg::*;

  step_t step;
  step_t step_next;
  logic  taken;

  assign ctrl = ucode_rom(step);

  // Evaluate the jump condition of the current step
  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:  taken = 1'b0;
      COND_ALWAYS: taken = 1'b1;
      COND_TICK:   taken = status.op_tick;
      COND_MORE:   taken = status.more;
      default:     taken = 1'b0;
    endcase
  end

  // Hold on a stall, else jump or fall through
  always_comb begin
    if (status.hold) begin
      step_next = step;
    end else if (taken) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> sv/tsq_dp.sv
// Datapath of the sleep queue: tick counter, sleeper table, scan and
// compaction pointers, pending wake result and output register.
// Depends on tsq_pkg and tsq_ram.
module tsq_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tsq_pkg::ucode_t                   ctrl,
  output tsq_pkg::dp_status_t               status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsq_pkg::ID_W-1:0]          cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tsq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tsq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [tsq_pkg::KIND_W-1:0]        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import tsq_pkg::*;

  // Registers
  logic [ID_W-1:0]    idle_id;
  logic [TICK_W-1:0]  tick;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   idx_next;
  logic [CNT_W-1:0]   keep;
  logic               pend_valid;
  logic [ID_W-1:0]    pend_id;
  logic [ID_W-1:0]    req_id;
  logic [DUR_W-1:0]   req_dur;
  logic               out_valid;
  kind_t              out_kind;
  logic [ID_W-1:0]    out_id;
  logic [TICK_W-1:0]  out_tick;
  logic               out_last;

  // Combinational
  logic               accept;
  logic               out_busy;
  logic [ENTRY_W-1:0] rd_entry;
  logic [ID_W-1:0]    entry_id;
  logic [TICK_W-1:0]  entry_wake;
  logic               scan_live;
  logic               woken;
  logic               scan_hold;
  logic               ignore_req;
  logic               table_full;
  logic [TICK_W:0]    wake_sum;
  logic [TICK_W-1:0]  wake_time;
  logic               emit;
  kind_t              emit_kind;
  logic [ID_W-1:0]    emit_id;
  logic               emit_last;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;

  assign cfg_ready     = !rst;
  assign s_axis_tready = !rst && (ctrl.act == ACT_FETCH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid && !m_axis_tready;

  assign entry_id   = rd_entry[ID_W-1:0];
  assign entry_wake = rd_entry[ENTRY_W-1:ID_W];
  assign scan_live  = (idx != count);
  assign woken      = (entry_wake <= tick);
  assign scan_hold  = scan_live && woken && pend_valid && out_busy;

  // Sleep decision and saturating wake time
  assign ignore_req = (req_dur == '0) || req_dur[DUR_W-1] || (req_id == idle_id);
  assign table_full = (count == CNT_W'(MAX_SLEEPERS));
  assign wake_sum   = {1'b0, tick} + (TICK_W+1)'(req_dur[DUR_W-2:0]);
  assign wake_time  = wake_sum[TICK_W] ? '1 : wake_sum[TICK_W-1:0];

  // Per-step emission, table write and scan pointer
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_NONE;
    emit_id   = '0;
    emit_last = 1'b1;
    we        = 1'b0;
    waddr     = count[ADDR_W-1:0];
    wdata     = {wake_time, req_id};
    idx_next  = idx;
    status    = '{hold: 1'b0, op_tick: s_axis_tuser, more: 1'b0, emit: 1'b0};
    unique case (ctrl.act)
      ACT_FETCH: begin
        status.hold = !s_axis_tvalid || rst;
      end
      ACT_SLEEP: begin
        status.hold = out_busy;
        emit        = !out_busy;
        emit_id     = req_id;
        if (ignore_req) begin
          emit_kind = KIND_IGNORED;
        end else if (table_full) begin
          emit_kind = KIND_FULL;
        end else begin
          emit_kind = KIND_QUEUED;
          we        = !out_busy;
        end
      end
      ACT_TSTART: begin
        idx_next = '0;
      end
      ACT_SCAN: begin
        status.hold = scan_hold;
        status.more = scan_live;
        if (scan_live && !scan_hold) begin
          idx_next = idx + CNT_W'(1);
          if (woken) begin
            // flush the previous woken thread, not yet known to be last
            emit      = pend_valid;
            emit_kind = KIND_WOKEN;
            emit_id   = pend_id;
            emit_last = 1'b0;
          end else begin
            // compact the surviving entry towards the front
            we    = 1'b1;
            waddr = keep[ADDR_W-1:0];
            wdata = rd_entry;
          end
        end
      end
      ACT_FINISH: begin
        status.hold = out_busy;
        emit        = !out_busy;
        emit_kind   = pend_valid ? KIND_WOKEN : KIND_NONE;
        emit_id     = pend_valid ? pend_id : '0;
      end
      default: begin
        status.hold = 1'b0;
      end
    endcase
    status.emit = emit;
  end

  tsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLEEPERS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_next[ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_id    <= '0;
      tick       <= '0;
      count      <= '0;
      idx        <= '0;
      keep       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_id <= cfg_data;
      end
      idx <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.act)
        ACT_SLEEP: begin
          if (we) begin
            count <= count + CNT_W'(1);
          end
        end
        ACT_TSTART: begin
          tick       <= tick + TICK_W'(1);
          keep       <= '0;
          pend_valid <= 1'b0;
        end
        ACT_SCAN: begin
          if (scan_live && !scan_hold) begin
            if (woken) begin
              pend_valid <= 1'b1;
            end else begin
              keep <= keep + CNT_W'(1);
            end
          end
        end
        ACT_FINISH: begin
          if (!out_busy) begin
            count      <= keep;
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id  <= s_axis_tdata[ID_W-1:0];
      req_dur <= s_axis_tdata[ID_W+DUR_W-1:ID_W];
    end
    if (ctrl.act == ACT_SCAN && scan_live && !scan_hold && woken) begin
      pend_id <= entry_id;
    end
    if (emit) begin
      out_kind <= emit_kind;
      out_id   <= emit_id;
      out_tick <= tick;
      out_last <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-ENTRY_W){1'b0}}, out_tick, out_id};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

>>> sv/timer_sleep_wakeup_queue.sv
// Timer sleep queue: a table of up to 16 sleeping threads with wake times.
//
// Input stream (s_axis): tuser is the operation (0 sleep request, 1 tick),
// tdata carries thread_id and a signed 32-bit duration. A sleep request
// queues the thread at wake time tick + duration (saturating), or answers
// ignored (duration not positive, or the idle thread) or table full.
// A tick advances the 63-bit tick counter, wakes every entry due at the new
// tick in table order and compacts the rest.
// Output stream (m_axis): tuser is the result kind, tdata the thread id and
// tick after the item, tlast marks the final result of an item.
// Configuration (cfg): one write sets the idle thread id; write only when
// the block is idle.
// Steps: a sleep request runs fetch and sleep; a tick runs fetch, tick start,
// scan and finish, the scan reading one table entry per cycle unless stalled,
// through the single read port of the table RAM. One item is in work at a
// time. A stalled receiver holds the output register and stops the scan.
// Reset clears the tick counter, the table fill count and the idle id.
`include "timer_sleep_wakeup_queue_defines.svh"

module timer_sleep_wakeup_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsq_pkg::ID_W-1:0]        cfg_data,       // idle_thread_id
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tsq_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // thread_id, duration
  input  logic                            s_axis_tuser,   // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tsq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // woken_id, now_tick, pad
  output logic [tsq_pkg::KIND_W-1:0]      m_axis_tuser,   // kind
  output logic                            m_axis_tlast
);
  import tsq_pkg::*;

  ucode_t     ctrl;
  dp_status_t status;

  tsq_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  tsq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A new result never overwrites one still waiting for the receiver
  `TSQ_ASSERT_NOW(a_no_overwrite, status.emit, !m_axis_tvalid || m_axis_tready)
  // An accepted beat always moves the sequencer off the fetch step
  `TSQ_ASSERT_NEXT(a_leave_fetch, s_axis_tvalid && s_axis_tready, ctrl.act != ACT_FETCH)
  // The nothing-woken result is always the last of its tick
  `TSQ_ASSERT_NOW(a_none_last, m_axis_tvalid && (m_axis_tuser == KIND_NONE), m_axis_tlast)

endmodule
